// ===== hdl/msfm_pkg.sv =====
`default_nettype none
package msfm_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 1'b1;

	// Field widths
	localparam int STRIDE_W = 6;
	localparam int ADDR_W   = 13;
	localparam int CNT_W    = 6;
	localparam int MAX_WRITES = 32;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 6'd32;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture the span at the input handshake
		logic calc;   // compute start address, count and masks
		logic step;   // advance to the next byte write
	} msfm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;  // span produces no writes
		logic last;   // current write is the final one
	} msfm_sts_t;

endpackage
`default_nettype wire

// ===== hdl/msfm_ctrl.sv =====
`default_nettype none
module msfm_ctrl
	import msfm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire msfm_sts_t sts,
	output msfm_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc  = 1'b1;
				state_nxt = sts.empty ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					cmd.step = 1'b1;
					if (sts.last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/msfm_dpath.sv =====
`default_nettype none
module msfm_dpath
	import msfm_pkg::*;
#(
	parameter int MAX_ROW_BYTES = 32,
	parameter int NUM_ROWS      = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire msfm_cmd_t           cmd,
	output msfm_sts_t                sts,
	input  wire logic [7:0]          span_x,
	input  wire logic [7:0]          span_y,
	input  wire logic [8:0]          span_len,
	input  wire logic [STRIDE_W-1:0] row_stride,
	output logic [ADDR_W-1:0]        byte_addr,
	output logic [7:0]               bit_mask,
	output logic                     last_write
);

	logic [7:0]          x_q, y_q;
	logic [8:0]          len_q;
	logic [STRIDE_W-1:0] stride_eff;
	logic [8:0]          row_px;
	logic [9:0]          end_sum, end_clip, end_m1;
	logic [4:0]          first_col;
	logic [5:0]          last_col;
	logic [6:0]          nbytes;
	logic                capped;
	logic [13:0]         row_base;
	logic [ADDR_W-1:0]   addr_start;
	logic [7:0]          lmask, rmask;
	logic                row_oob;

	logic [ADDR_W-1:0]   addr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                first_q;
	logic [7:0]          lmask_q, rmask_q;

	// Capture the span
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= span_x;
			y_q   <= span_y;
			len_q <= span_len;
		end
	end

	// Clip stride and span, find byte range and edge masks
	always_comb begin
		stride_eff = (32'(row_stride) > MAX_ROW_BYTES) ? STRIDE_W'(MAX_ROW_BYTES) : row_stride;
		row_px     = {stride_eff, 3'b000};
		end_sum    = {2'b00, x_q} + {1'b0, len_q};
		end_clip   = (end_sum > {1'b0, row_px}) ? {1'b0, row_px} : end_sum;
		end_m1     = end_clip - 10'd1;
		first_col  = x_q[7:3];
		last_col   = end_m1[8:3];
		nbytes     = {1'b0, last_col} - {2'b00, first_col} + 7'd1;
		capped     = nbytes > 7'(MAX_WRITES);
		row_base   = 14'(y_q) * 14'(stride_eff);
		addr_start = ADDR_W'(row_base + 14'(first_col));
		lmask      = 8'hFF << x_q[2:0];
		rmask      = 8'hFF >> (3'd7 - end_m1[2:0]);
		row_oob    = 32'(y_q) >= NUM_ROWS;
		sts.empty  = (len_q == 9'd0) || row_oob || ({1'b0, x_q} >= row_px);
		sts.last   = last_write;
	end

	// Write counter and first-write flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else if (cmd.calc) begin
			cnt_q   <= capped ? CNT_W'(MAX_WRITES) : CNT_W'(nbytes);
			first_q <= 1'b1;
		end else if (cmd.step) begin
			cnt_q   <= cnt_q - CNT_W'(1);
			first_q <= 1'b0;
		end
	end

	// Address and masks; a capped span keeps a full mask on its final write
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			addr_q  <= addr_start;
			lmask_q <= lmask;
			rmask_q <= capped ? 8'hFF : rmask;
		end else if (cmd.step) begin
			addr_q  <= addr_q + ADDR_W'(1);
		end
	end

	assign last_write = (cnt_q == CNT_W'(1));
	assign byte_addr  = addr_q;
	assign bit_mask   = (first_q ? lmask_q : 8'hFF) & (last_write ? rmask_q : 8'hFF);

endmodule
`default_nettype wire

// ===== hdl/mono_span_fill_mask_gen_core.sv =====
// Horizontal span fill for a 1-bit-per-pixel bitmap, pixels packed LSB first.
// Input channel (s_*): one item per span: column, row and length in pixels.
// Output channel (m_*): one item per touched byte, left to right: byte address,
// bit mask to modify, set/clear flag in tuser, and tlast on the span's final write.
// Configuration: write cfg_we with cfg_idx 0 for the fill value (1 sets, 0 clears)
// or cfg_idx 1 for the row stride in bytes; write only while the block is idle.
// A span is captured when accepted; the setup state computes its start address,
// write count and masks, and the emit state then presents the writes. A span
// that produces no writes returns to idle from setup. The setup state computes
// the row base with one small multiply; writes then leave the address counter
// at one per cycle unless stalled. At most 32 writes are given per span.
// When the receiver stalls, the current write holds and the block waits; a new
// span is taken only after the final write of the previous one is accepted.
// Reset returns the controller to idle, fill value to 0 and row stride to 32;
// no clearing pass is needed.
`default_nettype none
module mono_span_fill_mask_gen_core
	import msfm_pkg::*;
#(
	parameter int MAX_ROW_BYTES = 32,
	parameter int NUM_ROWS      = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [31:0]          s_tdata,   // span_x[7:0], span_y[15:8], span_len[24:16]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata,   // byte_addr[12:0], bit_mask[20:13]
	output logic                      m_tuser,   // set_bits
	output logic                      m_tlast,   // last_write
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [STRIDE_W-1:0]  cfg_wdata
);

	msfm_cmd_t           cmd;
	msfm_sts_t           sts;
	logic                fill_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [ADDR_W-1:0]   byte_addr;
	logic [7:0]          bit_mask;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 1'b0;
			stride_q <= STRIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FILL_VALUE: fill_q   <= cfg_wdata[0];
				CFG_ROW_STRIDE: stride_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	msfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msfm_dpath #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.NUM_ROWS      (NUM_ROWS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.span_x     (s_tdata[7:0]),
		.span_y     (s_tdata[15:8]),
		.span_len   (s_tdata[24:16]),
		.row_stride (stride_q),
		.byte_addr  (byte_addr),
		.bit_mask   (bit_mask),
		.last_write (m_tlast)
	);

	assign m_tdata = {3'b000, bit_mask, byte_addr};
	assign m_tuser = fill_q;

	// Input is never taken while a write is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("span accepted while a byte write is pending");

	// Final write ends the span's output
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output continues after final write");

	// A non-final write is followed by the next byte address
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && (m_tdata[12:0] == $past(m_tdata[12:0]) + 13'd1)))
		else $error("byte address did not advance by one");

endmodule
`default_nettype wire
